[design/dbe_pkg.sv]
// ----------------------------------------------------------------------------
// dbe_pkg
// Shared types and constants for the button debouncer with edge flags.
// ----------------------------------------------------------------------------
package dbe_pkg;

  localparam int unsigned NumButtons = 8;
  localparam int unsigned FieldW     = 8;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned DebW       = 16;

  localparam logic [DebW-1:0] DebounceMsReset = 16'd50;

  typedef enum logic [0:0] {
    ActRefresh = 1'b0,
    ActRead    = 1'b1
  } dbe_action_e;

  typedef struct packed {
    dbe_action_e       action;
    logic [FieldW-1:0] raw_buttons;
    logic [TimeW-1:0]  time_now;
    logic [FieldW-1:0] read_mask;
  } dbe_in_t;

  typedef struct packed {
    logic [FieldW-1:0] debounced;
    logic [FieldW-1:0] edge_up;
    logic [FieldW-1:0] edge_down;
    logic [FieldW-1:0] edge_any;
  } dbe_out_t;

  typedef struct packed {
    logic rise;
    logic fall;
  } dbe_lane_upd_t;

endpackage

[design/button_debouncer_with_edge_flags.sv]
// ----------------------------------------------------------------------------
// button_debouncer_with_edge_flags
// Debounces eight buttons and latches rising, falling and any-edge flags.
// ----------------------------------------------------------------------------
// Input transfers carry an action, the raw button byte, the millisecond time
// and a read mask. A refresh updates the debounced levels and sets sticky
// edge flags; a read returns the masked flags and clears them. Every input
// transfer yields exactly one result transfer with the debounced byte and
// the flags.
// The result is registered: an input register, then the per-button compare
// and flag update feed the result register. One item is taken every cycle
// unless the receiver stalls; each button lane does a single 32-bit age
// subtract and compare. The debounce time is written through debounce_we_i
// and debounce_wdata_i; the user must write it only while the block is
// idle; the block does not enforce this. Reset clears levels, start times
// and flags, sets the debounce time to 50 ms and empties both registers.
// When the receiver stalls, the result holds and the input register still
// fills; once both are full, in_stall_o rises until the result is taken.
// ----------------------------------------------------------------------------
module button_debouncer_with_edge_flags (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  dbe_pkg::dbe_in_t          in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output dbe_pkg::dbe_out_t         out_data_o,
  input  logic                      debounce_we_i,
  input  logic [dbe_pkg::DebW-1:0]  debounce_wdata_i
);
  import dbe_pkg::*;

  logic                  in_valid_q, in_valid_d;
  dbe_in_t               in_data_q;
  logic                  out_valid_q, out_valid_d;
  dbe_out_t              out_data_q, out_data_d;
  logic [DebW-1:0]       debounce_q;

  logic [NumButtons-1:0] level_q, level_d;
  logic [NumButtons-1:0] rise_q, rise_d;
  logic [NumButtons-1:0] fall_q, fall_d;
  logic [NumButtons-1:0] change_q, change_d;

  logic                  out_ready;
  logic                  move;
  logic                  in_take;
  logic                  do_refresh;
  logic [NumButtons-1:0] raw_ext;
  logic [NumButtons-1:0] mask_ext;
  logic [NumButtons-1:0] rise_set;
  logic [NumButtons-1:0] fall_set;
  dbe_lane_upd_t         upd [NumButtons];

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign move       = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_take    = in_valid_i && !in_stall_o;
  assign do_refresh = move && (in_data_q.action == ActRefresh);

  assign raw_ext  = NumButtons'(in_data_q.raw_buttons);
  assign mask_ext = NumButtons'(in_data_q.read_mask);

  for (genvar i = 0; i < NumButtons; i++) begin : g_lane
    dbe_lane u_lane (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .refresh_i     (do_refresh),
      .raw_i         (raw_ext[i]),
      .held_i        (level_q[i]),
      .time_now_i    (in_data_q.time_now),
      .debounce_ms_i (debounce_q),
      .upd_o         (upd[i])
    );
    assign rise_set[i] = upd[i].rise;
    assign fall_set[i] = upd[i].fall;
  end

  always_comb begin
    in_valid_d  = in_take ? 1'b1 : (move ? 1'b0 : in_valid_q);
    out_valid_d = move ? 1'b1 : (out_ready ? 1'b0 : out_valid_q);
    level_d     = level_q;
    rise_d      = rise_q;
    fall_d      = fall_q;
    change_d    = change_q;
    out_data_d  = out_data_q;
    if (move) begin
      case (in_data_q.action)
        ActRefresh: begin
          level_d              = (level_q | rise_set) & ~fall_set;
          rise_d               = rise_q | rise_set;
          fall_d               = fall_q | fall_set;
          change_d             = change_q | rise_set | fall_set;
          out_data_d.edge_up   = FieldW'(rise_d);
          out_data_d.edge_down = FieldW'(fall_d);
          out_data_d.edge_any  = FieldW'(change_d);
        end
        ActRead: begin
          rise_d               = rise_q & ~mask_ext;
          fall_d               = fall_q & ~mask_ext;
          change_d             = change_q & ~mask_ext;
          out_data_d.edge_up   = FieldW'(rise_q & mask_ext);
          out_data_d.edge_down = FieldW'(fall_q & mask_ext);
          out_data_d.edge_any  = FieldW'(change_q & mask_ext);
        end
        default: begin
          out_data_d = out_data_q;
        end
      endcase
      out_data_d.debounced = FieldW'(level_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      debounce_q  <= DebounceMsReset;
      level_q     <= '0;
      rise_q      <= '0;
      fall_q      <= '0;
      change_q    <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      level_q     <= level_d;
      rise_q      <= rise_d;
      fall_q      <= fall_d;
      change_q    <= change_d;
      if (debounce_we_i) begin
        debounce_q <= debounce_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q <= in_data_i;
    end
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_change_is_rise_or_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    change_q == (rise_q | fall_q))
    else $error("any-edge flags differ from rising or falling flags");

  a_result_any_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.edge_any == (out_data_o.edge_up | out_data_o.edge_down)))
    else $error("result any-edge flags inconsistent");

  a_full_pipe_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("input taken while both registers are full");

  a_no_flag_without_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_refresh && (in_data_q.action == ActRefresh)) |=> ((rise_q & ~$past(rise_q)) & ~level_q) == '0)
    else $error("rising flag set without a high debounced level");

endmodule

[design/dbe_lane.sv]
// ----------------------------------------------------------------------------
// dbe_lane
// One button: holds its start time and decides whether a changed level has
// persisted longer than the debounce time.
// ----------------------------------------------------------------------------
module dbe_lane (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        refresh_i,
  input  logic                        raw_i,
  input  logic                        held_i,
  input  logic [dbe_pkg::TimeW-1:0]   time_now_i,
  input  logic [dbe_pkg::DebW-1:0]    debounce_ms_i,
  output dbe_pkg::dbe_lane_upd_t      upd_o
);
  import dbe_pkg::*;

  logic [TimeW-1:0] start_q;
  logic [TimeW-1:0] start_d;
  logic [TimeW-1:0] age;
  logic             accept;

  assign age    = time_now_i - start_q;
  assign accept = (raw_i != held_i) && (age > TimeW'(debounce_ms_i));

  assign upd_o.rise = accept && raw_i;
  assign upd_o.fall = accept && !raw_i;

  always_comb begin
    start_d = start_q;
    if (refresh_i && (raw_i == held_i)) begin
      start_d = time_now_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
    end else begin
      start_q <= start_d;
    end
  end

endmodule
